/* design/ncli_pkg.sv */
package ncli_pkg;

	// table geometry and number format
	localparam int MAX_ENTRIES = 1024;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int ENTRY_W     = 10;
	localparam int LEN_W       = 24;
	localparam int FRAC_W      = 8;
	localparam int OUT_W       = 11;

	// jump start: floor((4*L + 3*S) / (6*S)) as a shift by FRAC_W+1, then a divide by three
	localparam int SCALE  = 1 << FRAC_W;
	localparam int NUM_W  = LEN_W + 3;
	localparam int X_W    = NUM_W - FRAC_W - 1;
	localparam int RCP_SH = X_W + 1;
	localparam longint RCP = ((longint'(1) << RCP_SH) + 2) / 3;
	localparam int PROD_W = X_W + RCP_SH;

	// datapath commands issued by the controller
	typedef struct packed {
		logic load;
		logic take;
		logic calc;
		logic check;
		logic start;
		logic step;
		logic emit;
	} cmd_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic in_query;
		logic no_table;
		logic edge_hit;
		logic jump_over;
		logic walk_done;
	} stat_t;

endpackage

/* design/ncli_if.sv */
interface ncli_in_if;
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic [ncli_pkg::ENTRY_W-1:0]     entry_index;
	logic [ncli_pkg::LEN_W-1:0]       value;
	logic                             last_entry;

	modport source (output valid, mode, entry_index, value, last_entry, input ready);
	modport sink (input valid, mode, entry_index, value, last_entry, output ready);
endinterface

interface ncli_out_if;
	logic                         valid;
	logic                         ready;
	logic [ncli_pkg::OUT_W-1:0]   closest_index;

	modport source (output valid, closest_index, input ready);
	modport sink (input valid, closest_index, output ready);
endinterface

/* design/ncli_ram.sv */
module ncli_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* design/ncli_datapath.sv */
module ncli_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ncli_pkg::cmd_t                   cmd,
	output ncli_pkg::stat_t                  stat,
	input  logic                             item_mode,
	input  logic [ncli_pkg::ENTRY_W-1:0]     item_entry_index,
	input  logic [ncli_pkg::LEN_W-1:0]       item_value,
	input  logic                             item_last_entry,
	output logic [ncli_pkg::OUT_W-1:0]       result_index
);
	import ncli_pkg::*;

	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  first_q;
	logic [LEN_W-1:0]  last_q;
	logic [CNT_W-1:0]  count_q;
	logic [PROD_W-1:0] prod_s1;
	logic              edge_s1;
	logic [CNT_W-1:0]  edge_res_s1;
	logic [ADDR_W-1:0] j_q;
	logic [LEN_W-1:0]  dist_q;
	logic [CNT_W-1:0]  res_q;
	logic [OUT_W-1:0]  out_q;

	logic              load_ok;
	logic [ADDR_W-1:0] load_addr;
	logic [CNT_W-1:0]  last_idx_c;
	logic [ADDR_W-1:0] last_idx;
	logic [NUM_W-1:0]  num;
	logic [X_W-1:0]    x;
	logic [X_W-1:0]    q;
	logic [ADDR_W-1:0] q_addr;
	logic              below;
	logic              below_ans;
	logic              above;
	logic              above_ans;
	logic [LEN_W-1:0]  above_diff;
	logic              jump_over;
	logic [LEN_W-1:0]  rdata;
	logic              start_low;
	logic [LEN_W-1:0]  dist_next;
	logic              walk_done;
	logic [ADDR_W-1:0] ram_addr;

	// table writes, dropped beyond the table
	assign load_ok   = (32'(item_entry_index) < MAX_ENTRIES);
	assign load_addr = item_entry_index[ADDR_W-1:0];

	assign last_idx_c = count_q - CNT_W'(1);
	assign last_idx   = last_idx_c[ADDR_W-1:0];

	// jump start estimate round(L / 1.5)
	assign num = NUM_W'({len_q, 2'b00}) + NUM_W'(3 * SCALE);
	assign x   = num[NUM_W-1:FRAC_W+1];
	assign q   = prod_s1[PROD_W-1:RCP_SH];
	assign q_addr    = q[ADDR_W-1:0];
	assign jump_over = (q > X_W'(last_idx));

	// queries outside the table range
	assign below      = (len_q < first_q);
	assign below_ans  = ({len_q, 1'b0} < {1'b0, first_q});
	assign above      = (len_q > last_q);
	assign above_diff = len_q - last_q;
	assign above_ans  = ({above_diff, 1'b0} < {1'b0, first_q});

	// walk compare against the entry read last cycle
	assign start_low = (len_q < rdata);
	assign dist_next = (len_q >= rdata) ? (len_q - rdata) : (rdata - len_q);
	assign walk_done = (j_q == last_idx) || (dist_q < dist_next);

	// table address select
	always_comb begin
		ram_addr = j_q + ADDR_W'(2);
		if (cmd.load) begin
			ram_addr = load_addr;
		end else if (cmd.check) begin
			ram_addr = jump_over ? ADDR_W'(1) : q_addr;
		end else if (cmd.start) begin
			ram_addr = start_low ? ADDR_W'(1) : q_addr + ADDR_W'(1);
		end
	end

	ncli_ram #(
		.WIDTH(LEN_W),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (cmd.load && load_ok),
		.addr (ram_addr),
		.wdata(item_value),
		.rdata(rdata)
	);

	// entry count, resets with the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load && load_ok && item_last_entry) begin
			count_q <= CNT_W'(item_entry_index) + CNT_W'(1);
		end
	end

	// shadow copies of the first and last table entries
	always_ff @(posedge clk) begin
		if (cmd.load && load_ok) begin
			if (item_entry_index == '0) begin
				first_q <= item_value;
			end
			if (item_last_entry || (CNT_W'(item_entry_index) == last_idx_c)) begin
				last_q <= item_value;
			end
		end
	end

	// query pipeline and walk registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			len_q <= item_value;
		end
		if (cmd.calc) begin
			prod_s1     <= PROD_W'(x) * PROD_W'(RCP);
			edge_s1     <= below || above;
			edge_res_s1 <= (below ? below_ans : above_ans) ? count_q : CNT_W'(1);
		end
		if (cmd.check) begin
			if (edge_s1) begin
				res_q <= edge_res_s1;
			end else if (jump_over) begin
				j_q    <= '0;
				dist_q <= len_q - first_q;
			end
		end
		if (cmd.start) begin
			if (start_low) begin
				j_q    <= '0;
				dist_q <= len_q - first_q;
			end else begin
				j_q    <= q_addr;
				dist_q <= len_q - rdata;
			end
		end
		if (cmd.step) begin
			if (walk_done) begin
				res_q <= CNT_W'(j_q) + CNT_W'(1);
			end else begin
				j_q    <= j_q + ADDR_W'(1);
				dist_q <= dist_next;
			end
		end
		if (cmd.emit) begin
			out_q <= OUT_W'(res_q);
		end
	end

	assign result_index = out_q;

	assign stat.in_query  = item_mode;
	assign stat.no_table  = (count_q == '0);
	assign stat.edge_hit  = edge_s1;
	assign stat.jump_over = jump_over;
	assign stat.walk_done = walk_done;

endmodule

/* design/ncli_ctrl.sv */
module ncli_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	output logic            result_valid,
	input  logic            result_ready,
	input  ncli_pkg::stat_t stat,
	output ncli_pkg::cmd_t  cmd
);
	import ncli_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CALC  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_WALK  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_vld_q;
	logic       out_free;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_vld_q;
	assign out_free     = !out_vld_q || result_ready;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (!stat.in_query) begin
						cmd.load = 1'b1;
					end else if (!stat.no_table) begin
						cmd.take = 1'b1;
						state_d  = ST_CALC;
					end
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (stat.edge_hit) begin
					state_d = ST_DONE;
				end else if (stat.jump_over) begin
					state_d = ST_WALK;
				end else begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = ST_WALK;
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (stat.walk_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (result_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

/* design/nearest_cumulative_length_index.sv */
// channel | dir | beat contents
// --------+-----+------------------------------------------------
// item    | in  | mode, entry_index, value (Q16.8), last_entry
// result  | out | closest_index (one-based)
//
// a load beat is written into the table as it is accepted; a query runs calc and check,
// then done when it falls outside the table range, else start (skipped when the jump
// start overshoots) and a walk, one entry per cycle through the single table port.
// arst_n clears the entry count and control; table contents are undefined until loaded.
// the output register holds a finished beat while the next items are accepted;
// a new query result waits in place until that register frees.
module nearest_cumulative_length_index (
	input  logic        clk,
	input  logic        arst_n,
	ncli_in_if.sink     item,
	ncli_out_if.source  result
);
	import ncli_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ncli_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_ready  (item.ready),
		.result_valid(result.valid),
		.result_ready(result.ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	ncli_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.item_mode       (item.mode),
		.item_entry_index(item.entry_index),
		.item_value      (item.value),
		.item_last_entry (item.last_entry),
		.result_index    (result.closest_index)
	);

endmodule
